// ===== design/crt_pkg.sv =====
// Shared types and codes for the cell registry table.
package crt_pkg;
   typedef enum logic [2:0] {
      OP_RESET     = 3'd0,
      OP_NSEI_FAIL = 3'd1,
      OP_FIND_LINK = 3'd2,
      OP_FIND_RA   = 3'd3,
      OP_FIND_LA   = 3'd4,
      OP_PAGE      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   localparam int AREA_W  = 45;
   localparam int ENTRY_W = AREA_W + 48;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      logic [15:0]       cid;
      logic [15:0]       nsei;
      logic [15:0]       bvci;
   } entry_type;
endpackage

// ===== design/crt_mem.sv =====
// Entry memory with one write port and one registered read port.
module crt_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  crt_pkg::entry_type     wr_data,
   input  logic [AW-1:0]          rd_addr,
   output crt_pkg::entry_type     rd_data
);
   crt_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/cell_registry_table_unit.sv =====
// Top level of the cell registry table: sequencer, valid bits and entry memory.
// Each operation scans the table at one entry per cycle through the memory read port,
// except while a stalled output holds a page_ra scan; its final word is loaded in S_RESP
// once the scan ends and the output is free, for reset_ind after the S_WRITE write-back.
// page_ra loads each earlier word as the next match is found. One operation is taken at
// a time: the next is taken in the cycle after the final word loads.
// Reset empties the table at once by clearing the valid bits.
module cell_registry_table_unit #(
   parameter int MAX_CELLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [9:0]  req_mcc,
   input  logic [9:0]  req_mnc,
   input  logic        req_mnc_three_digits,
   input  logic [15:0] req_lac,
   input  logic [7:0]  req_rac,
   input  logic [15:0] req_cell_id,
   input  logic [15:0] req_nsei,
   input  logic [15:0] req_bvci,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_nsei,
   output logic [15:0] rsp_out_bvci,
   output logic [15:0] rsp_out_cell_id,
   output logic [9:0]  rsp_out_mcc,
   output logic [9:0]  rsp_out_mnc,
   output logic        rsp_out_mnc_three,
   output logic [15:0] rsp_out_lac,
   output logic [7:0]  rsp_out_rac,
   output logic        rsp_last
);
   localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CW = AW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN1, S_WRITE, S_SCAN2, S_PAGE_HOLD, S_RESP
   } state_type;

   state_type           state_ff;
   crt_pkg::op_type     op_ff;
   logic [crt_pkg::AREA_W-1:0] area_ff;
   logic [15:0]         cell_ff, nsei_ff, bvci_ff;
   logic [MAX_CELLS-1:0] valid_ff;
   logic [CW-1:0]       addr_ff;
   logic                pend_ff;
   logic [AW-1:0]       pidx_ff;
   logic                any_ff, ra_hit_ff, la_hit_ff, found_ff;
   logic [AW-1:0]       ra_idx_ff, la_idx_ff;
   crt_pkg::entry_type  hit_ent_ff;
   logic                havep_ff;
   crt_pkg::entry_type  pent_ff;

   logic                mem_we;
   logic [AW-1:0]       mem_wa, mem_ra;
   crt_pkg::entry_type  mem_wd, rd;
   logic [MAX_CELLS-1:0] valid_wr;

   crt_mem #(.DEPTH(MAX_CELLS), .AW(AW)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(rd)
   );

   logic v_p, m_area, m_ra, m_la, m_link, m_nsei;
   always_comb begin
      v_p    = pend_ff && valid_ff[pidx_ff];
      m_area = v_p && rd.area == area_ff;
      m_ra   = m_area && rd.cid == cell_ff;
      m_la   = v_p && rd.area[crt_pkg::AREA_W-1:8] == area_ff[crt_pkg::AREA_W-1:8]
               && rd.cid == cell_ff;
      m_link = v_p && rd.nsei == nsei_ff && rd.bvci == bvci_ff && bvci_ff != 16'd0;
      m_nsei = v_p && rd.nsei == nsei_ff;
   end

   logic out_free, rsp_load, page_emit, page_stall;
   assign out_free = !rsp_valid || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign page_emit = (state_ff == S_SCAN1 || state_ff == S_SCAN2) &&
                      op_ff == crt_pkg::OP_PAGE && pend_ff && m_area && havep_ff;
   assign page_stall = page_emit && !out_free;
   assign rsp_load = out_free && (state_ff == S_RESP || state_ff == S_PAGE_HOLD || page_emit);

   always_comb begin
      if (page_stall || (state_ff == S_PAGE_HOLD && !out_free)) mem_ra = pidx_ff;
      else mem_ra = addr_ff[AW-1:0];
   end

   logic [AW-1:0] free_idx;
   logic          free_ok;
   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = MAX_CELLS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   always_comb begin
      mem_we   = 1'b0;
      mem_wa   = free_idx;
      mem_wd   = '{area: area_ff, cid: cell_ff, nsei: nsei_ff, bvci: bvci_ff};
      valid_wr = valid_ff;
      if (state_ff == S_WRITE) begin
         if (any_ff && ra_hit_ff) begin
            mem_we = 1'b1;
            mem_wa = ra_idx_ff;
         end else if (free_ok || (any_ff && la_hit_ff)) begin
            mem_we = 1'b1;
            if (any_ff && la_hit_ff) begin
               valid_wr[la_idx_ff] = 1'b0;
               if (!free_ok || la_idx_ff < free_idx) mem_wa = la_idx_ff;
            end
            valid_wr[mem_wa] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         rsp_valid <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff     <= crt_pkg::op_type'(req_operation);
                  area_ff   <= {req_mcc, req_mnc, req_mnc_three_digits, req_lac, req_rac};
                  cell_ff   <= req_cell_id;
                  nsei_ff   <= req_nsei;
                  bvci_ff   <= req_bvci;
                  addr_ff   <= '0;
                  pend_ff   <= 1'b0;
                  any_ff    <= 1'b0;
                  ra_hit_ff <= 1'b0;
                  la_hit_ff <= 1'b0;
                  found_ff  <= 1'b0;
                  havep_ff  <= 1'b0;
                  state_ff  <= S_SCAN1;
               end
            end
            S_SCAN1, S_SCAN2: begin
               if (pend_ff) begin
                  unique case (op_ff)
                     crt_pkg::OP_RESET: begin
                        if (m_area) any_ff <= 1'b1;
                        if (m_ra && !ra_hit_ff) begin
                           ra_hit_ff <= 1'b1;
                           ra_idx_ff <= pidx_ff;
                        end
                        if (m_la && !la_hit_ff) begin
                           la_hit_ff <= 1'b1;
                           la_idx_ff <= pidx_ff;
                        end
                     end
                     crt_pkg::OP_NSEI_FAIL: begin
                        if (m_nsei) begin
                           valid_ff[pidx_ff] <= 1'b0;
                           found_ff <= 1'b1;
                        end
                     end
                     crt_pkg::OP_FIND_LINK, crt_pkg::OP_FIND_RA, crt_pkg::OP_FIND_LA: begin
                        if (!found_ff && ((op_ff == crt_pkg::OP_FIND_LINK && m_link) ||
                              (op_ff == crt_pkg::OP_FIND_RA && m_ra) ||
                              (op_ff == crt_pkg::OP_FIND_LA && m_la))) begin
                           found_ff   <= 1'b1;
                           hit_ent_ff <= rd;
                        end
                     end
                     default: ;
                  endcase
               end
               if (page_emit) begin
                  if (out_free) begin
                     rsp_status        <= crt_pkg::ST_OK;
                     {rsp_out_mcc, rsp_out_mnc, rsp_out_mnc_three, rsp_out_lac,
                      rsp_out_rac}     <= pent_ff.area;
                     rsp_out_cell_id   <= pent_ff.cid;
                     rsp_out_nsei      <= pent_ff.nsei;
                     rsp_out_bvci      <= pent_ff.bvci;
                     rsp_last          <= 1'b0;
                     pent_ff           <= rd;
                     if (addr_ff == CW'(MAX_CELLS)) begin
                        pend_ff  <= 1'b0;
                        state_ff <= S_RESP;
                     end else begin
                        pidx_ff <= addr_ff[AW-1:0];
                        pend_ff <= 1'b1;
                        addr_ff <= addr_ff + 1'b1;
                     end
                  end else begin
                     state_ff <= S_PAGE_HOLD;
                  end
               end else begin
                  if (op_ff == crt_pkg::OP_PAGE && pend_ff && m_area) begin
                     havep_ff <= 1'b1;
                     pent_ff  <= rd;
                  end
                  if (addr_ff == CW'(MAX_CELLS)) begin
                     pend_ff <= 1'b0;
                     if (op_ff == crt_pkg::OP_RESET && state_ff == S_SCAN1)
                        state_ff <= S_WRITE;
                     else state_ff <= S_RESP;
                  end else begin
                     pidx_ff <= addr_ff[AW-1:0];
                     pend_ff <= 1'b1;
                     addr_ff <= addr_ff + 1'b1;
                  end
               end
            end
            S_PAGE_HOLD: begin
               if (out_free) begin
                  rsp_status <= crt_pkg::ST_OK;
                  {rsp_out_mcc, rsp_out_mnc, rsp_out_mnc_three, rsp_out_lac,
                   rsp_out_rac} <= pent_ff.area;
                  rsp_out_cell_id <= pent_ff.cid;
                  rsp_out_nsei    <= pent_ff.nsei;
                  rsp_out_bvci    <= pent_ff.bvci;
                  rsp_last        <= 1'b0;
                  pent_ff         <= rd;
                  if (addr_ff == CW'(MAX_CELLS)) begin
                     pend_ff  <= 1'b0;
                     state_ff <= S_RESP;
                  end else begin
                     pidx_ff  <= addr_ff[AW-1:0];
                     pend_ff  <= 1'b1;
                     addr_ff  <= addr_ff + 1'b1;
                     state_ff <= S_SCAN1;
                  end
               end
            end
            S_WRITE: begin
               found_ff <= mem_we;
               valid_ff <= valid_wr;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_last  <= 1'b1;
                  {rsp_out_mcc, rsp_out_mnc, rsp_out_mnc_three, rsp_out_lac,
                   rsp_out_rac, rsp_out_cell_id, rsp_out_nsei, rsp_out_bvci} <= '0;
                  priority case (op_ff)
                     crt_pkg::OP_RESET:
                        rsp_status <= found_ff ? crt_pkg::ST_OK : crt_pkg::ST_FULL;
                     crt_pkg::OP_NSEI_FAIL:
                        rsp_status <= found_ff ? crt_pkg::ST_OK : crt_pkg::ST_NOT_FOUND;
                     crt_pkg::OP_FIND_LINK, crt_pkg::OP_FIND_RA, crt_pkg::OP_FIND_LA: begin
                        rsp_status <= found_ff ? crt_pkg::ST_OK : crt_pkg::ST_NOT_FOUND;
                        if (found_ff) begin
                           {rsp_out_mcc, rsp_out_mnc, rsp_out_mnc_three, rsp_out_lac,
                            rsp_out_rac} <= hit_ent_ff.area;
                           rsp_out_cell_id <= hit_ent_ff.cid;
                           rsp_out_nsei    <= hit_ent_ff.nsei;
                           rsp_out_bvci    <= hit_ent_ff.bvci;
                        end
                     end
                     crt_pkg::OP_PAGE: begin
                        rsp_status <= havep_ff ? crt_pkg::ST_OK : crt_pkg::ST_NOT_FOUND;
                        if (havep_ff) begin
                           {rsp_out_mcc, rsp_out_mnc, rsp_out_mnc_three, rsp_out_lac,
                            rsp_out_rac} <= pent_ff.area;
                           rsp_out_cell_id <= pent_ff.cid;
                           rsp_out_nsei    <= pent_ff.nsei;
                           rsp_out_bvci    <= pent_ff.bvci;
                        end
                     end
                     default: rsp_status <= crt_pkg::ST_NOT_FOUND;
                  endcase
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== tb/cell_registry_table_unit_test.sv =====
// Self-checking testbench for the cell registry table: directed table, then pooled random traffic.
module cell_registry_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CELLS     = 64;
   localparam logic [2:0]  OP_SPARE6 = 3'd6;
   localparam logic [2:0]  OP_SPARE7 = 3'd7;
   localparam int          N_RANDOM  = 400;
   localparam int          TAIL      = 2 * CELLS + 10;

   typedef struct packed {
      logic [2:0]  op;
      logic [9:0]  mcc;
      logic [9:0]  mnc;
      logic        three;
      logic [15:0] lac;
      logic [7:0]  rac;
      logic [15:0] cid;
      logic [15:0] nsei;
      logic [15:0] bvci;
      logic        known;
      crt_pkg::status_type status;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] nsei;
      logic [15:0] bvci;
      logic [15:0] cid;
      logic [9:0]  mcc;
      logic [9:0]  mnc;
      logic        three;
      logic [15:0] lac;
      logic [7:0]  rac;
      logic        last;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation = '0;
   logic [9:0]  req_mcc = '0;
   logic [9:0]  req_mnc = '0;
   logic        req_mnc_three_digits = 1'b0;
   logic [15:0] req_lac = '0;
   logic [7:0]  req_rac = '0;
   logic [15:0] req_cell_id = '0;
   logic [15:0] req_nsei = '0;
   logic [15:0] req_bvci = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_nsei;
   logic [15:0] rsp_out_bvci;
   logic [15:0] rsp_out_cell_id;
   logic [9:0]  rsp_out_mcc;
   logic [9:0]  rsp_out_mnc;
   logic        rsp_out_mnc_three;
   logic [15:0] rsp_out_lac;
   logic [7:0]  rsp_out_rac;
   logic        rsp_last;

   cell_registry_table_unit #(.MAX_CELLS(CELLS)) u_dut (.*);

   always #4 clock = ~clock;

   // shadow copy of the table
   bit                         cell_used [CELLS];
   logic [crt_pkg::AREA_W-1:0] cell_area [CELLS];
   logic [15:0]                cell_code [CELLS];
   logic [15:0]                cell_nsei [CELLS];
   logic [15:0]                cell_bvci [CELLS];

   word_type    pending_words [$];
   int          errors = 0;
   int          words_seen = 0;
   int          pages_sent = 0;
   int          full_seen = 0;
   int          send_idle = 24;
   int          recv_idle = 68;
   bit          hold_armed = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_cycles = 0;

   logic [crt_pkg::AREA_W-1:0] area_pool [4];
   logic [15:0]                nsei_pool [6];

   function automatic word_type table_word(crt_pkg::status_type st, int idx, bit last);
      word_type w;
      w = '0;
      w.status = st;
      w.last = last;
      if (idx >= 0) begin
         {w.mcc, w.mnc, w.three, w.lac, w.rac} = cell_area[idx];
         w.nsei = cell_nsei[idx];
         w.bvci = cell_bvci[idx];
         w.cid = cell_code[idx];
      end
      return w;
   endfunction

   function automatic int lowest_match(logic [crt_pkg::AREA_W-1:0] area, bit la_only,
                                       logic [15:0] cid);
      for (int i = 0; i < CELLS; i++)
         if (cell_used[i] && cell_code[i] == cid &&
             (la_only ? cell_area[i][crt_pkg::AREA_W-1:8] == area[crt_pkg::AREA_W-1:8]
                      : cell_area[i] == area))
            return i;
      return -1;
   endfunction

   task automatic apply_cmd(cmd_type c);
      logic [crt_pkg::AREA_W-1:0] area;
      int hit;
      int prev;
      bit any;
      area = {c.mcc, c.mnc, c.three, c.lac, c.rac};
      hit = -1;
      any = 1'b0;
      case (c.op)
         crt_pkg::OP_RESET: begin
            for (int i = 0; i < CELLS; i++)
               if (cell_used[i] && cell_area[i] == area) any = 1'b1;
            if (any) begin
               hit = lowest_match(area, 1'b0, c.cid);
               if (hit >= 0) begin
                  cell_nsei[hit] = c.nsei;
                  cell_bvci[hit] = c.bvci;
                  pending_words.push_back(table_word(crt_pkg::ST_OK, -1, 1'b1));
                  return;
               end
               hit = lowest_match(area, 1'b1, c.cid);
               if (hit >= 0) cell_used[hit] = 1'b0;
            end
            for (int i = 0; i < CELLS; i++)
               if (!cell_used[i]) begin
                  cell_used[i] = 1'b1;
                  cell_area[i] = area;
                  cell_code[i] = c.cid;
                  cell_nsei[i] = c.nsei;
                  cell_bvci[i] = c.bvci;
                  pending_words.push_back(table_word(crt_pkg::ST_OK, -1, 1'b1));
                  return;
               end
            pending_words.push_back(table_word(crt_pkg::ST_FULL, -1, 1'b1));
         end
         crt_pkg::OP_NSEI_FAIL: begin
            for (int i = 0; i < CELLS; i++)
               if (cell_used[i] && cell_nsei[i] == c.nsei) begin
                  cell_used[i] = 1'b0;
                  any = 1'b1;
               end
            pending_words.push_back(table_word(any ? crt_pkg::ST_OK : crt_pkg::ST_NOT_FOUND,
                                               -1, 1'b1));
         end
         crt_pkg::OP_FIND_LINK: begin
            if (c.bvci != 0)
               for (int i = 0; i < CELLS; i++)
                  if (hit < 0 && cell_used[i] && cell_nsei[i] == c.nsei &&
                      cell_bvci[i] == c.bvci)
                     hit = i;
            pending_words.push_back(table_word(hit >= 0 ? crt_pkg::ST_OK
                                                        : crt_pkg::ST_NOT_FOUND, hit, 1'b1));
         end
         crt_pkg::OP_FIND_RA, crt_pkg::OP_FIND_LA: begin
            hit = lowest_match(area, c.op == crt_pkg::OP_FIND_LA, c.cid);
            pending_words.push_back(table_word(hit >= 0 ? crt_pkg::ST_OK
                                                        : crt_pkg::ST_NOT_FOUND, hit, 1'b1));
         end
         crt_pkg::OP_PAGE: begin
            prev = -1;
            for (int i = 0; i < CELLS; i++)
               if (cell_used[i] && cell_area[i] == area) begin
                  if (prev >= 0) pending_words.push_back(table_word(crt_pkg::ST_OK, prev, 1'b0));
                  prev = i;
               end
            pending_words.push_back(prev < 0 ? table_word(crt_pkg::ST_NOT_FOUND, -1, 1'b1)
                                             : table_word(crt_pkg::ST_OK, prev, 1'b1));
         end
         default: pending_words.push_back(table_word(crt_pkg::ST_NOT_FOUND, -1, 1'b1));
      endcase
   endtask

   function automatic cmd_type random_cmd();
      cmd_type c;
      int pick;
      logic [63:0] r64;
      c = '0;
      pick = $urandom_range(99);
      if (pick < 45) c.op = crt_pkg::OP_RESET;
      else if (pick < 50) c.op = crt_pkg::OP_NSEI_FAIL;
      else if (pick < 62) c.op = crt_pkg::OP_FIND_LINK;
      else if (pick < 74) c.op = crt_pkg::OP_FIND_RA;
      else if (pick < 84) c.op = crt_pkg::OP_FIND_LA;
      else if (pick < 97) c.op = crt_pkg::OP_PAGE;
      else c.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
      if ($urandom_range(99) < 12) begin
         r64 = {$urandom, $urandom};
         {c.mcc, c.mnc, c.three, c.lac, c.rac} = r64[crt_pkg::AREA_W-1:0];
         c.cid = 16'($urandom);
         c.nsei = 16'($urandom);
         c.bvci = 16'($urandom);
      end else begin
         {c.mcc, c.mnc, c.three, c.lac, c.rac} = area_pool[$urandom_range(3)];
         c.cid = 16'($urandom_range(23));
         c.nsei = nsei_pool[$urandom_range(5)];
         c.bvci = 16'($urandom_range(12));
      end
      return c;
   endfunction

   task automatic refresh_pools();
      logic [crt_pkg::AREA_W-9:0] lai;
      logic [63:0] r64;
      for (int k = 0; k < 2; k++) begin
         r64 = {$urandom, $urandom};
         lai = r64[crt_pkg::AREA_W-9:0];
         area_pool[2*k]   = {lai, 8'($urandom)};
         area_pool[2*k+1] = {lai, 8'($urandom)};
      end
      for (int k = 0; k < 6; k++) nsei_pool[k] = 16'($urandom);
   endtask

   task automatic send_cmd(cmd_type c);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= c.op;
      req_mcc <= c.mcc;
      req_mnc <= c.mnc;
      req_mnc_three_digits <= c.three;
      req_lac <= c.lac;
      req_rac <= c.rac;
      req_cell_id <= c.cid;
      req_nsei <= c.nsei;
      req_bvci <= c.bvci;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_cmd(c);
      if (c.op == crt_pkg::OP_PAGE) pages_sent++;
      if (c.known && pending_words[$].status !== c.status) begin
         errors++;
         if (errors <= 10)
            $display("directed op %0d: typed status %0d, predicted %0d",
                     c.op, c.status, pending_words[$].status);
      end
      @(negedge clock);
   endtask

   cmd_type directed [22] = '{
      '{crt_pkg::OP_FIND_LINK, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd1,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{crt_pkg::OP_PAGE, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{crt_pkg::OP_NSEI_FAIL, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{crt_pkg::OP_FIND_RA, 10'd262, 10'd1, 1'b0, 16'd5, 8'd1, 16'd0, 16'd0, 16'd0,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{crt_pkg::OP_RESET, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd1,
        1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_RESET, 10'h3FF, 10'h3FF, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_RESET, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd7, 16'd9,
        1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_FIND_LINK, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd7, 16'd0,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{crt_pkg::OP_FIND_LINK, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd7, 16'd9,
        1'b0, crt_pkg::ST_OK},
      '{crt_pkg::OP_FIND_LINK, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF,
        1'b0, crt_pkg::ST_OK},
      '{crt_pkg::OP_FIND_RA, 10'h3FF, 10'h3FF, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd0, 16'd0,
        1'b0, crt_pkg::ST_OK},
      '{crt_pkg::OP_RESET, 10'd0, 10'd0, 1'b0, 16'd0, 8'd1, 16'd0, 16'd3, 16'd4,
        1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_FIND_LA, 10'd0, 10'd0, 1'b0, 16'd0, 8'd77, 16'd0, 16'd0, 16'd0,
        1'b0, crt_pkg::ST_OK},
      '{crt_pkg::OP_RESET, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd5, 16'd3, 16'd5,
        1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_RESET, 10'd0, 10'd0, 1'b0, 16'd0, 8'd1, 16'd5, 16'd3, 16'd6,
        1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_FIND_RA, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd5, 16'd0, 16'd0,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{crt_pkg::OP_RESET, 10'd0, 10'd0, 1'b0, 16'd0, 8'd1, 16'd8, 16'd3, 16'd8,
        1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_PAGE, 10'd0, 10'd0, 1'b0, 16'd0, 8'd1, 16'd0, 16'd0, 16'd0,
        1'b0, crt_pkg::ST_OK},
      '{OP_SPARE6, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{OP_SPARE7, 10'h3FF, 10'h3FF, 1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        1'b1, crt_pkg::ST_NOT_FOUND},
      '{crt_pkg::OP_NSEI_FAIL, 10'd0, 10'd0, 1'b0, 16'd0, 8'd0, 16'd0, 16'd3, 16'd0,
        1'b1, crt_pkg::ST_OK},
      '{crt_pkg::OP_PAGE, 10'd0, 10'd0, 1'b0, 16'd0, 8'd1, 16'd0, 16'd0, 16'd0,
        1'b1, crt_pkg::ST_NOT_FOUND}
   };

   always @(negedge clock) begin
      if (hold_armed && !hold_done) begin
         hold_done <= 1'b1;
         hold_cycles <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      word_type got;
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_out_nsei, rsp_out_bvci, rsp_out_cell_id, rsp_out_mcc,
                rsp_out_mnc, rsp_out_mnc_three, rsp_out_lac, rsp_out_rac, rsp_last};
         words_seen++;
         if (rsp_status == crt_pkg::ST_FULL) full_seen++;
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %p", got);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("word mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("** cell_registry_table_unit: FAILED **");
      $finish;
   end

   initial begin
      int n;
      int waited;
      for (int i = 0; i < CELLS; i++) cell_used[i] = 1'b0;
      refresh_pools();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_cmd(directed[i]);
      for (n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_idle = 68;
            recv_idle = 24;
            refresh_pools();
         end else if (n == 2 * N_RANDOM / 3) begin
            send_idle = 0;
            recv_idle = 0;
            hold_armed = 1'b1;
            refresh_pools();
         end
         send_cmd(random_cmd());
      end
      req_valid <= 1'b0;
      waited = 0;
      while (pending_words.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL) @(posedge clock);
      if (pending_words.size() != 0) begin
         errors++;
         $display("%0d expected words never arrived", pending_words.size());
      end
      $display("%0d operations sent (%0d pages), %0d words checked, %0d table-full replies",
               $size(directed) + N_RANDOM, pages_sent, words_seen, full_seen);
      $display("%0d mismatches", errors);
      if (errors == 0)
         $display("** cell_registry_table_unit: PASSED **");
      else
         $display("** cell_registry_table_unit: FAILED **");
      $finish;
   end
endmodule
